FILE: rtl/klrb_pkg.sv
// Shared types and constants for the keymap layer report builder.
// Used by klrb_store and keymap_layer_report_builder_unit; no dependencies.
package klrb_pkg;

    // Default sizes for the top-level parameters
    localparam int NUM_KEYS_DEF     = 64;
    localparam int NUM_LAYERS_DEF   = 8;
    localparam int REPORT_SLOTS_DEF = 6;

    // Report layout
    localparam int VISIBLE_SLOTS = 6;
    localparam int MAX_BUTTON    = 5;

    // Command codes
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_LOAD   = 2'd2;

    // Action codes
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_REGULAR   = 3'd1;
    localparam logic [2:0] ACT_TAP_HOLD  = 3'd2;
    localparam logic [2:0] ACT_SET_LAYER = 3'd3;
    localparam logic [2:0] ACT_MOUSE     = 3'd4;

    // Configuration register map
    localparam int         CFG_IDX_W         = 1;
    localparam int         CFG_DATA_W        = 16;
    localparam logic [0:0] CFG_TAP_LIMIT     = 1'd0;
    localparam logic [0:0] CFG_LAYERS_IN_USE = 1'd1;
    localparam logic [15:0] TAP_LIMIT_RST    = 16'd200;
    localparam logic [3:0]  LAYERS_RST       = 4'd8;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] code_a;
        logic [7:0] code_b;
    } entry_t;

    // Active copy entry: keymap entry plus its tap flag
    typedef struct packed {
        entry_t entry;
        logic   tap;
    } act_t;

    typedef struct packed {
        logic tbl_we;
        logic act_we;
    } store_ctl_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  key_index;
        logic        pressed;
        logic [15:0] held_time;
        logic        last_key;
        logic [2:0]  layer_index;
        logic [2:0]  entry_action;
        logic [7:0]  entry_code_a;
        logic [7:0]  entry_code_b;
    } in_t;

    typedef struct packed {
        logic [7:0] keycode_0;
        logic [7:0] keycode_1;
        logic [7:0] keycode_2;
        logic [7:0] keycode_3;
        logic [7:0] keycode_4;
        logic [7:0] keycode_5;
        logic [5:0] mouse_mask;
        logic       any_event;
    } out_t;

endpackage

FILE: rtl/klrb_store.sv
// Layer table and active keymap copy, each one write and one registered read port.
// Depends on klrb_pkg for entry and control types.
module klrb_store #(
    parameter int KEY_W   = 6,
    parameter int LAYER_W = 3
) (
    input  logic                       aclk,
    input  klrb_pkg::store_ctl_t       ctl,
    input  logic [LAYER_W+KEY_W-1:0]   tbl_waddr,
    input  klrb_pkg::entry_t           tbl_wdata,
    input  logic [LAYER_W+KEY_W-1:0]   tbl_raddr,
    output klrb_pkg::entry_t           tbl_rdata,
    input  logic [KEY_W-1:0]           act_waddr,
    input  klrb_pkg::act_t             act_wdata,
    input  logic [KEY_W-1:0]           act_raddr,
    output klrb_pkg::act_t             act_rdata
);

    localparam int TBL_DEPTH = 1 << (LAYER_W + KEY_W);
    localparam int ACT_DEPTH = 1 << KEY_W;

    klrb_pkg::entry_t tbl_mem [TBL_DEPTH];
    klrb_pkg::act_t   act_mem [ACT_DEPTH];
    klrb_pkg::entry_t tbl_rdata_reg;
    klrb_pkg::act_t   act_rdata_reg;

    // Layer table: write then registered read
    always_ff @(posedge aclk) begin
        if (ctl.tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rdata_reg <= tbl_mem[tbl_raddr];
    end

    // Active copy: write then registered read
    always_ff @(posedge aclk) begin
        if (ctl.act_we) begin
            act_mem[act_waddr] <= act_wdata;
        end
        act_rdata_reg <= act_mem[act_raddr];
    end

    assign tbl_rdata = tbl_rdata_reg;
    assign act_rdata = act_rdata_reg;

endmodule

FILE: rtl/keymap_layer_report_builder_unit.sv
// Keymap layer report builder top level: sequencer, report accumulators, config.
// Depends on klrb_pkg and klrb_store.
//
//   port group   dir  handshake          payload
//   s_*          in   s_valid/s_ready    klrb_pkg::in_t  (command, key sample, entry)
//   m_*          out  m_valid/m_ready    klrb_pkg::out_t (boot report)
//   cfg_*        in   cfg_we             cfg_index, cfg_wdata
//
// A key sample is an active copy read, then an update; an entry write is taken on accept.
// A layer load, by command or by a set-layer key, adds one table read and one
// active-copy write per key through the single memory ports.
// After reset a clearing pass over all 2^(clog2(NUM_LAYERS)+clog2(NUM_KEYS)) table
// addresses (512 by default) zeroes both memories; s_ready stays low until it is done.
// A last-key sample waits in its update cycle while the output register is still full.
module keymap_layer_report_builder_unit #(
    parameter int NUM_KEYS     = klrb_pkg::NUM_KEYS_DEF,
    parameter int NUM_LAYERS   = klrb_pkg::NUM_LAYERS_DEF,
    parameter int REPORT_SLOTS = klrb_pkg::REPORT_SLOTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  klrb_pkg::in_t                      s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output klrb_pkg::out_t                     m_data,
    input  logic                               cfg_we,
    input  logic [klrb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [klrb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int KEY_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int LAYER_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
    localparam int TBL_W   = KEY_W + LAYER_W;
    localparam int SLOT_IW = (REPORT_SLOTS > 1) ? $clog2(REPORT_SLOTS) : 1;
    localparam int SLOT_CW = $clog2(REPORT_SLOTS + 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_PROC  = 2'd2;
    localparam logic [1:0] S_LOAD  = 2'd3;

    logic [1:0]          state_reg, state_next;
    klrb_pkg::in_t       item_reg;
    logic [TBL_W-1:0]    clr_cnt_reg;
    logic [LAYER_W-1:0]  ld_layer_reg, ld_layer_next;
    logic [KEY_W:0]      ld_cnt_reg;
    logic                ld_wv_reg;
    logic [KEY_W-1:0]    ld_wa_reg;
    logic [7:0]          codes_reg [REPORT_SLOTS];
    logic [7:0]          codes_next [REPORT_SLOTS];
    logic [SLOT_CW-1:0]  slot_cnt_reg, slot_cnt_next;
    logic [5:0]          btn_reg, btn_next;
    logic                fired_reg, fired_next;
    logic                m_valid_reg;
    klrb_pkg::out_t      m_data_reg;
    logic [15:0]         tap_limit_reg;
    logic [3:0]          layers_reg;

    // Input decode
    logic        accept;
    logic [8:0]  key_ext;
    logic [4:0]  layer_ext;
    logic        key_ok, layer_ok, load_ok;

    // Store interface
    klrb_pkg::store_ctl_t ctl;
    logic [TBL_W-1:0]     tbl_waddr, tbl_raddr;
    klrb_pkg::entry_t     tbl_wdata, tbl_rdata;
    logic [KEY_W-1:0]     act_waddr, act_raddr;
    klrb_pkg::act_t       act_wdata, act_rdata;

    // Update-cycle signals
    klrb_pkg::entry_t ent;
    logic [8:0]  ikey_ext;
    logic        ikey_ok, held_gt, out_busy, proc_go, emit;
    logic        add_en, fire, ld_req, tap_new;
    logic [7:0]  add_code;
    logic [5:0]  btn_set;
    logic [7:0]  vis [klrb_pkg::VISIBLE_SLOTS];
    klrb_pkg::out_t report;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign key_ext   = 9'(s_data.key_index);
    assign layer_ext = 5'(s_data.layer_index);
    assign key_ok    = key_ext < 9'(NUM_KEYS);
    assign layer_ok  = layer_ext < 5'(NUM_LAYERS);
    assign load_ok   = layer_ok && (layer_ext < 5'(layers_reg));

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_limit_reg <= klrb_pkg::TAP_LIMIT_RST;
            layers_reg    <= klrb_pkg::LAYERS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                klrb_pkg::CFG_TAP_LIMIT:     tap_limit_reg <= cfg_wdata;
                klrb_pkg::CFG_LAYERS_IN_USE: layers_reg    <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Memory port steering: clearing pass, entry write, layer copy, tap write-back
    always_comb begin
        ctl.tbl_we = 1'b0;
        ctl.act_we = 1'b0;
        tbl_waddr  = {layer_ext[LAYER_W-1:0], key_ext[KEY_W-1:0]};
        tbl_wdata  = '{action: s_data.entry_action, code_a: s_data.entry_code_a,
                       code_b: s_data.entry_code_b};
        act_waddr  = ikey_ext[KEY_W-1:0];
        act_wdata  = '{entry: ent, tap: tap_new};
        if (state_reg == S_CLEAR) begin
            ctl.tbl_we = 1'b1;
            ctl.act_we = 1'b1;
            tbl_waddr  = clr_cnt_reg;
            tbl_wdata  = '0;
            act_waddr  = clr_cnt_reg[KEY_W-1:0];
            act_wdata  = '0;
        end else if (state_reg == S_IDLE) begin
            ctl.tbl_we = accept && (s_data.command == klrb_pkg::CMD_WRITE) &&
                         key_ok && layer_ok;
        end else if (state_reg == S_LOAD) begin
            ctl.act_we = ld_wv_reg;
            act_waddr  = ld_wa_reg;
            act_wdata  = '{entry: tbl_rdata, tap: 1'b0};
        end else begin
            ctl.act_we = proc_go && ikey_ok;
        end
    end

    // Read the offered key while idle, hold the accepted key's entry afterwards
    assign tbl_raddr = {ld_layer_reg, ld_cnt_reg[KEY_W-1:0]};
    assign act_raddr = (state_reg == S_IDLE) ? key_ext[KEY_W-1:0] : ikey_ext[KEY_W-1:0];

    klrb_store #(
        .KEY_W   (KEY_W),
        .LAYER_W (LAYER_W)
    ) u_store (
        .aclk      (aclk),
        .ctl       (ctl),
        .tbl_waddr (tbl_waddr),
        .tbl_wdata (tbl_wdata),
        .tbl_raddr (tbl_raddr),
        .tbl_rdata (tbl_rdata),
        .act_waddr (act_waddr),
        .act_wdata (act_wdata),
        .act_raddr (act_raddr),
        .act_rdata (act_rdata)
    );

    // Decode the sampled key's action
    assign ent      = act_rdata.entry;
    assign ikey_ext = 9'(item_reg.key_index);
    assign ikey_ok  = ikey_ext < 9'(NUM_KEYS);
    assign held_gt  = item_reg.held_time > tap_limit_reg;
    assign out_busy = m_valid_reg && !m_ready;
    assign proc_go  = !(item_reg.last_key && out_busy);
    assign emit     = (state_reg == S_PROC) && proc_go && item_reg.last_key;

    always_comb begin
        add_en   = 1'b0;
        add_code = ent.code_a;
        tap_new  = act_rdata.tap;
        fire     = 1'b0;
        ld_req   = 1'b0;
        btn_set  = '0;
        if (ikey_ok) begin
            unique case (ent.action)
                klrb_pkg::ACT_REGULAR: begin
                    add_en = item_reg.pressed;
                end
                klrb_pkg::ACT_TAP_HOLD: begin
                    if (item_reg.pressed) begin
                        if (held_gt) begin
                            tap_new  = 1'b0;
                            add_en   = 1'b1;
                            add_code = ent.code_b;
                        end else begin
                            tap_new = 1'b1;
                        end
                    end else if (act_rdata.tap) begin
                        tap_new = 1'b0;
                        add_en  = 1'b1;
                    end
                end
                klrb_pkg::ACT_SET_LAYER: begin
                    if (item_reg.pressed) begin
                        fire   = 1'b1;
                        ld_req = (ent.code_a < 8'(NUM_LAYERS)) &&
                                 (ent.code_a < 8'(layers_reg));
                    end
                end
                klrb_pkg::ACT_MOUSE: begin
                    if (item_reg.pressed) begin
                        fire = 1'b1;
                        if (ent.code_a <= 8'(klrb_pkg::MAX_BUTTON)) begin
                            btn_set = 6'(1) << ent.code_a[2:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Accumulate the report; drop codes once every slot is taken
    always_comb begin
        codes_next    = codes_reg;
        slot_cnt_next = slot_cnt_reg;
        if (add_en && (slot_cnt_reg < SLOT_CW'(REPORT_SLOTS))) begin
            codes_next[slot_cnt_reg[SLOT_IW-1:0]] = add_code;
            slot_cnt_next = slot_cnt_reg + SLOT_CW'(1);
        end
        btn_next   = btn_reg | btn_set;
        fired_next = fired_reg | fire | add_en;
    end

    for (genvar j = 0; j < klrb_pkg::VISIBLE_SLOTS; j++) begin : g_vis
        if (j < REPORT_SLOTS) begin : g_used
            assign vis[j] = codes_next[j];
        end else begin : g_unused
            assign vis[j] = '0;
        end
    end

    assign report = '{keycode_0: vis[0], keycode_1: vis[1], keycode_2: vis[2],
                      keycode_3: vis[3], keycode_4: vis[4], keycode_5: vis[5],
                      mouse_mask: btn_next, any_event: fired_next};

    // Sequencer next state
    always_comb begin
        state_next    = state_reg;
        ld_layer_next = ld_layer_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_cnt_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && (s_data.command == klrb_pkg::CMD_SAMPLE)) begin
                    state_next = S_PROC;
                end else if (accept && (s_data.command == klrb_pkg::CMD_LOAD) && load_ok) begin
                    state_next    = S_LOAD;
                    ld_layer_next = layer_ext[LAYER_W-1:0];
                end
            end
            S_PROC: begin
                if (proc_go) begin
                    if (ld_req) begin
                        state_next    = S_LOAD;
                        ld_layer_next = ent.code_a[LAYER_W-1:0];
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_LOAD: begin
                if (ld_cnt_reg == (KEY_W+1)'(NUM_KEYS)) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer registers and layer copy counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            ld_layer_reg <= '0;
            ld_cnt_reg   <= '0;
            ld_wv_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ld_layer_reg <= ld_layer_next;
            if (state_reg == S_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + TBL_W'(1);
            end
            if (state_reg == S_LOAD) begin
                if (ld_cnt_reg < (KEY_W+1)'(NUM_KEYS)) begin
                    ld_cnt_reg <= ld_cnt_reg + (KEY_W+1)'(1);
                    ld_wv_reg  <= 1'b1;
                end else begin
                    ld_wv_reg  <= 1'b0;
                end
            end else begin
                ld_cnt_reg <= '0;
                ld_wv_reg  <= 1'b0;
            end
        end
    end

    // Hold the accepted transaction
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        ld_wa_reg <= ld_cnt_reg[KEY_W-1:0];
    end

    // Report accumulators: advance on each sample, clear after the last key
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REPORT_SLOTS; i++) begin
                codes_reg[i] <= '0;
            end
            slot_cnt_reg <= '0;
            btn_reg      <= '0;
            fired_reg    <= 1'b0;
        end else if ((state_reg == S_PROC) && proc_go) begin
            if (item_reg.last_key) begin
                for (int i = 0; i < REPORT_SLOTS; i++) begin
                    codes_reg[i] <= '0;
                end
                slot_cnt_reg <= '0;
                btn_reg      <= '0;
                fired_reg    <= 1'b0;
            end else begin
                codes_reg    <= codes_next;
                slot_cnt_reg <= slot_cnt_next;
                btn_reg      <= btn_next;
                fired_reg    <= fired_next;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= report;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_cnt_reg <= SLOT_CW'(REPORT_SLOTS))
        else $error("slot count above report size");

    a_emit_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_PROC)
        else $error("report raised outside the update cycle");

    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (slot_cnt_reg == '0) && !fired_reg && (btn_reg == '0))
        else $error("accumulators not cleared after report");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(m_data_reg))
        else $error("pending report overwritten");

    a_copy_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ld_wv_reg |-> (state_reg == S_LOAD) && (ld_wa_reg < KEY_W'(NUM_KEYS - 1) ||
                       ld_wa_reg == KEY_W'(NUM_KEYS - 1)))
        else $error("layer copy write outside key range");

endmodule

FILE: verif/klrb_report_checker.sv
// Scoreboard for the keymap layer report builder: tracks the s_/m_/cfg_ ports and
// predicts every boot report from its own copy of the keymap state.
// Depends on klrb_pkg for the payload structs, command and action codes.
module klrb_report_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  klrb_pkg::in_t                   s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  klrb_pkg::out_t                  m_data,
    input  logic                            cfg_we,
    input  logic [klrb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [klrb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              mismatch_count,
    output int                              reports_waiting,
    output int                              items_seen,
    output int                              reports_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NKEYS   = klrb_pkg::NUM_KEYS_DEF;
    localparam int NLAYERS = klrb_pkg::NUM_LAYERS_DEF;
    localparam int NSLOTS  = klrb_pkg::REPORT_SLOTS_DEF;

    // Predicted keymap state and report accumulators
    klrb_pkg::entry_t layer_map [NLAYERS][NKEYS];
    klrb_pkg::entry_t live_map [NKEYS];
    bit               tap_armed [NKEYS];
    logic [7:0]       slot_code [NSLOTS];
    int               slots_used;
    logic [5:0]       button_mask;
    bit               fired;
    logic [15:0]      hold_threshold;
    logic [3:0]       layer_limit;
    klrb_pkg::out_t   expected_reports [$];

    function automatic void clear_report_state();
        for (int j = 0; j < NSLOTS; j++) slot_code[j] = '0;
        slots_used  = 0;
        button_mask = '0;
        fired       = 1'b0;
    endfunction

    function automatic void reset_keymap_state();
        for (int l = 0; l < NLAYERS; l++)
            for (int k = 0; k < NKEYS; k++) layer_map[l][k] = '0;
        for (int k = 0; k < NKEYS; k++) begin
            live_map[k]  = '0;
            tap_armed[k] = 1'b0;
        end
        clear_report_state();
        hold_threshold = klrb_pkg::TAP_LIMIT_RST;
        layer_limit    = klrb_pkg::LAYERS_RST;
        expected_reports.delete();
    endfunction

    // Copy a layer into the live map; out-of-range layers leave it alone
    function automatic void copy_layer(input int unsigned lyr);
        if (lyr >= layer_limit || lyr >= NLAYERS) return;
        for (int k = 0; k < NKEYS; k++) begin
            live_map[k]  = layer_map[lyr][k];
            tap_armed[k] = 1'b0;
        end
    endfunction

    // Append a keycode while slots remain; drop it once the report is full
    function automatic void add_keycode(input logic [7:0] code);
        if (slots_used < NSLOTS) begin
            slot_code[slots_used] = code;
            slots_used++;
        end
        fired = 1'b1;
    endfunction

    function automatic void apply_key_sample(input int unsigned key, input logic pressed,
                                             input logic [15:0] held);
        klrb_pkg::entry_t e;
        if (key >= NKEYS) return;
        e = live_map[key];
        case (e.action)
            klrb_pkg::ACT_REGULAR: begin
                if (pressed) add_keycode(e.code_a);
            end
            klrb_pkg::ACT_TAP_HOLD: begin
                if (pressed) begin
                    if (held > hold_threshold) begin
                        tap_armed[key] = 1'b0;
                        add_keycode(e.code_b);
                    end else begin
                        tap_armed[key] = 1'b1;
                    end
                end else if (tap_armed[key]) begin
                    tap_armed[key] = 1'b0;
                    add_keycode(e.code_a);
                end
            end
            klrb_pkg::ACT_SET_LAYER: begin
                if (pressed) begin
                    copy_layer(e.code_a);
                    fired = 1'b1;
                end
            end
            klrb_pkg::ACT_MOUSE: begin
                if (pressed) begin
                    if (e.code_a <= klrb_pkg::MAX_BUTTON)
                        button_mask = button_mask | 6'(1 << e.code_a);
                    fired = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    // Advance the keymap state by one transaction; returns 1 when a report is due
    function automatic bit predict_keymap_item(input klrb_pkg::in_t it,
                                               output klrb_pkg::out_t rpt);
        rpt = '0;
        case (it.command)
            klrb_pkg::CMD_WRITE: begin
                if (it.key_index < NKEYS && it.layer_index < NLAYERS) begin
                    layer_map[it.layer_index][it.key_index].action = it.entry_action;
                    layer_map[it.layer_index][it.key_index].code_a = it.entry_code_a;
                    layer_map[it.layer_index][it.key_index].code_b = it.entry_code_b;
                end
            end
            klrb_pkg::CMD_LOAD: copy_layer(it.layer_index);
            klrb_pkg::CMD_SAMPLE: begin
                apply_key_sample(it.key_index, it.pressed, it.held_time);
                if (it.last_key) begin
                    rpt.keycode_0  = slot_code[0];
                    rpt.keycode_1  = slot_code[1];
                    rpt.keycode_2  = slot_code[2];
                    rpt.keycode_3  = slot_code[3];
                    rpt.keycode_4  = slot_code[4];
                    rpt.keycode_5  = slot_code[5];
                    rpt.mouse_mask = button_mask;
                    rpt.any_event  = fired;
                    clear_report_state();
                    return 1'b1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: report field %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    // Compare results first, then take config and the incoming transaction
    always @(posedge aclk) begin
        klrb_pkg::out_t want;
        klrb_pkg::out_t rpt;
        if (!aresetn) begin
            reset_keymap_state();
            mismatch_count = 0;
            items_seen     = 0;
            reports_seen   = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: report with none expected, expected nothing, actual %h",
                             $time, m_data);
                end else begin
                    want = expected_reports.pop_front();
                    reports_seen++;
                    check_field("keycode_0", want.keycode_0, m_data.keycode_0);
                    check_field("keycode_1", want.keycode_1, m_data.keycode_1);
                    check_field("keycode_2", want.keycode_2, m_data.keycode_2);
                    check_field("keycode_3", want.keycode_3, m_data.keycode_3);
                    check_field("keycode_4", want.keycode_4, m_data.keycode_4);
                    check_field("keycode_5", want.keycode_5, m_data.keycode_5);
                    check_field("mouse_mask", 8'(want.mouse_mask), 8'(m_data.mouse_mask));
                    check_field("any_event", 8'(want.any_event), 8'(m_data.any_event));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    klrb_pkg::CFG_TAP_LIMIT:     hold_threshold = cfg_wdata;
                    klrb_pkg::CFG_LAYERS_IN_USE: layer_limit    = cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                items_seen++;
                if (predict_keymap_item(s_data, rpt)) expected_reports.push_back(rpt);
            end
        end
        reports_waiting = expected_reports.size();
    end

endmodule

FILE: verif/keymap_layer_report_builder_unit_tb.sv
// Testbench top for keymap_layer_report_builder_unit: clock, reset, config writes,
// directed and random keymap traffic with idle/stall phases, and the verdict.
// Depends on klrb_pkg, the RTL top, and klrb_report_checker.
module keymap_layer_report_builder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_RESERVED     = 2'd3;
    localparam logic [2:0] ACT_UNUSED_7     = 3'd7;
    localparam int         SETTLE_CYCLES    = 100;
    localparam int         LONG_HOLD_CYCLES = 400;
    localparam int         CYCLE_LIMIT      = 2000000;
    localparam int         ITEMS_PER_PHASE  = 500;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    klrb_pkg::in_t                   s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    klrb_pkg::out_t                  m_data;
    logic                            cfg_we    = 1'b0;
    logic [klrb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [klrb_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    int          mismatch_count;
    int          reports_waiting;
    int          items_seen;
    int          reports_seen;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          hold_on        = 1'b0;
    int          hold_left      = LONG_HOLD_CYCLES;
    logic [15:0] cur_tap        = klrb_pkg::TAP_LIMIT_RST;
    int          hot_key [8];
    int          random_items;
    klrb_pkg::in_t noise;

    always #5 aclk = ~aclk;

    keymap_layer_report_builder_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    klrb_report_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .reports_waiting (reports_waiting),
        .items_seen      (items_seen),
        .reports_seen    (reports_seen)
    );

    // Count cycles for the watchdog
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("run stopped at the cycle limit with %0d reports outstanding", reports_waiting);
        $display("FAIL");
        $finish;
    end

    // Drive m_ready: one long hold-off when requested, random stalls otherwise
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_on && hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic klrb_pkg::in_t mk_sample(input int key, input logic pressed,
                                                input logic [15:0] held, input logic last);
        klrb_pkg::in_t it;
        it           = '0;
        it.command   = klrb_pkg::CMD_SAMPLE;
        it.key_index = 6'(key);
        it.pressed   = pressed;
        it.held_time = held;
        it.last_key  = last;
        return it;
    endfunction

    function automatic klrb_pkg::in_t mk_write(input int lyr, input int key,
                                               input logic [2:0] act,
                                               input logic [7:0] a, input logic [7:0] b);
        klrb_pkg::in_t it;
        it              = '0;
        it.command      = klrb_pkg::CMD_WRITE;
        it.layer_index  = 3'(lyr);
        it.key_index    = 6'(key);
        it.entry_action = act;
        it.entry_code_a = a;
        it.entry_code_b = b;
        return it;
    endfunction

    function automatic klrb_pkg::in_t mk_load(input int lyr);
        klrb_pkg::in_t it;
        it             = '0;
        it.command     = klrb_pkg::CMD_LOAD;
        it.layer_index = 3'(lyr);
        return it;
    endfunction

    // Offer one transaction, with an optional idle gap first; valid stays up after
    task automatic send_item(input klrb_pkg::in_t it);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait out every expected report plus the load latency
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (reports_waiting != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [15:0] tap, input logic [3:0] layers);
        cfg_we    <= 1'b1;
        cfg_index <= klrb_pkg::CFG_TAP_LIMIT;
        cfg_wdata <= tap;
        @(posedge aclk);
        cfg_index <= klrb_pkg::CFG_LAYERS_IN_USE;
        cfg_wdata <= 16'(layers);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_tap    = tap;
    endtask

    // Held times cluster around the tap threshold, with the extremes mixed in
    function automatic logic [15:0] pick_hold();
        case ($urandom_range(0, 7))
            0: return cur_tap - 16'd1;
            1: return cur_tap;
            2: return cur_tap + 16'd1;
            3: return 16'd0;
            4: return 16'hFFFF;
            5, 6: return 16'($urandom_range(0, 400));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_key();
        if ($urandom_range(99) < 75) return hot_key[$urandom_range(0, 7)];
        return $urandom_range(0, 63);
    endfunction

    task automatic send_random_write();
        int          r;
        logic [2:0]  act;
        logic [7:0]  a;
        r = $urandom_range(99);
        if (r < 30)      act = klrb_pkg::ACT_REGULAR;
        else if (r < 60) act = klrb_pkg::ACT_TAP_HOLD;
        else if (r < 70) act = klrb_pkg::ACT_SET_LAYER;
        else if (r < 85) act = klrb_pkg::ACT_MOUSE;
        else if (r < 93) act = klrb_pkg::ACT_NONE;
        else             act = 3'($urandom_range(5, 7));
        a = 8'($urandom);
        if (act == klrb_pkg::ACT_SET_LAYER && $urandom_range(99) < 85)
            a = 8'($urandom_range(0, 7));
        if (act == klrb_pkg::ACT_MOUSE && $urandom_range(99) < 80)
            a = 8'($urandom_range(0, klrb_pkg::MAX_BUTTON));
        send_item(mk_write($urandom_range(0, 7), pick_key(), act, a, 8'($urandom)));
    endtask

    // One scan: hot keys in ascending order, some neighbors, last flag on the final one
    task automatic send_random_scan();
        int scan_keys [$];
        for (int i = 0; i < 8; i++) begin
            if ($urandom_range(99) < 70) scan_keys.push_back(hot_key[i]);
            if ($urandom_range(99) < 15 && hot_key[i] < i * 8 + 7)
                scan_keys.push_back($urandom_range(hot_key[i] + 1, i * 8 + 7));
        end
        if (scan_keys.size() == 0) scan_keys.push_back($urandom_range(0, 63));
        foreach (scan_keys[i])
            send_item(mk_sample(scan_keys[i], $urandom_range(99) < 55, pick_hold(),
                                i == scan_keys.size() - 1));
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input logic [15:0] tap,
                             input logic [3:0] layers, input bit long_hold);
        int            start_items;
        int            r;
        klrb_pkg::in_t noise;
        logic [63:0]   noise_bits;
        settle();
        write_config(tap, layers);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < 8; i++) hot_key[i] = i * 8 + $urandom_range(0, 7);
        if (long_hold) hold_on = 1'b1;
        start_items = items_seen;
        while (items_seen - start_items < ITEMS_PER_PHASE) begin
            r = $urandom_range(99);
            if (r < 40) begin
                repeat ($urandom_range(1, 4)) send_random_write();
            end else if (r < 47) begin
                send_item(mk_load($urandom_range(0, 7)));
            end else if (r < 50) begin
                // Noise: any field pattern, reserved command included
                noise_bits = {$urandom, $urandom};
                noise      = noise_bits[$bits(klrb_pkg::in_t)-1:0];
                send_item(noise);
            end else begin
                send_random_scan();
            end
        end
        random_items += items_seen - start_items;
    endtask

    initial begin
        random_items = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: every non-empty action on layer 0, set-layer target on layer 7
        send_item(mk_write(0, 0, klrb_pkg::ACT_REGULAR, 8'h04, 8'h00));
        send_item(mk_write(0, 1, klrb_pkg::ACT_TAP_HOLD, 8'h05, 8'hFF));
        send_item(mk_write(0, 2, klrb_pkg::ACT_SET_LAYER, 8'd7, 8'h00));
        send_item(mk_write(0, 3, klrb_pkg::ACT_MOUSE, 8'd5, 8'h00));
        send_item(mk_write(0, 4, klrb_pkg::ACT_MOUSE, 8'hFF, 8'h00));
        send_item(mk_write(0, 5, ACT_UNUSED_7, 8'hFF, 8'hFF));
        send_item(mk_write(7, 63, klrb_pkg::ACT_REGULAR, 8'hFF, 8'h00));
        send_item(mk_load(0));
        // Reserved command with last_key set must be ignored
        noise          = '0;
        noise.command  = CMD_RESERVED;
        noise.last_key = 1'b1;
        send_item(noise);
        // Regular, tap arm, top mouse button, out-of-range button, unknown action
        send_item(mk_sample(0, 1'b1, 16'd0, 1'b0));
        send_item(mk_sample(1, 1'b1, 16'd0, 1'b0));
        send_item(mk_sample(3, 1'b1, 16'd0, 1'b0));
        send_item(mk_sample(4, 1'b1, 16'hFFFF, 1'b0));
        send_item(mk_sample(5, 1'b1, 16'd0, 1'b1));
        // Quick release gives the tap code, long press the hold code
        send_item(mk_sample(1, 1'b0, 16'd0, 1'b0));
        send_item(mk_sample(1, 1'b1, 16'hFFFF, 1'b1));
        // Overfill the report, then switch layer mid-scan
        repeat (5) send_item(mk_sample(0, 1'b1, 16'd1, 1'b0));
        send_item(mk_sample(1, 1'b1, 16'hFFFF, 1'b0));
        send_item(mk_sample(2, 1'b1, 16'd0, 1'b0));
        send_item(mk_sample(63, 1'b1, 16'd0, 1'b1));
        // Scan where nothing fires
        send_item(mk_sample(10, 1'b0, 16'd0, 1'b1));

        run_phase(0, 0, 16'd0, 4'd8, 1'b1);
        run_phase(66, 0, 16'hFFFF, 4'd1, 1'b0);
        run_phase(0, 66, 16'($urandom_range(0, 1000)), 4'($urandom_range(1, 8)), 1'b0);
        run_phase(17, 17, 16'd300, 4'd8, 1'b0);
        settle();

        $display("covered %0d transactions (%0d random) and %0d reports over four phases",
                 items_seen, random_items, reports_seen);
        $display("tap limit 0 to 65535, layers in use 1 to 8, idle/stall mixes incl. a long hold");
        if (reports_waiting != 0)
            $display("%0t: %0d expected reports never arrived", $time, reports_waiting);
        if (mismatch_count == 0 && reports_waiting == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
